// ----- design/ordered_list_positional_engine_top_assert.svh -----
// Assertion macros for the ordered list engine.
// Included by the top level; needs a clock and an active-low reset in scope.
`ifndef ORDERED_LIST_POSITIONAL_ENGINE_TOP_ASSERT_SVH
`define ORDERED_LIST_POSITIONAL_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTH
`define OLPE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define OLPE_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) else $error(msg);
`else
`define OLPE_ASSERT(lbl, clk, rstn, prop, msg)
`define OLPE_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg)
`endif

`endif

// ----- design/olpe_pkg.sv -----
// Shared types and constants for the ordered list engine.
// No dependencies; imported by the interfaces, the cell and the top level.
package olpe_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int VAL_W  = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int FIDX_W = 4;
    localparam int ST_W   = 2;
    localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_EXTRACT = 3'd1,
        OP_READ    = 3'd2,
        OP_FIND    = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
    } cell_ctl_t;

endpackage

// ----- design/olpe_req_if.sv -----
// Request channel of the ordered list engine: one operation per beat.
// Depends on olpe_pkg for field widths.
interface olpe_req_if
    import olpe_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;

    modport source (output valid, op, item_value, position, input ready);
    modport sink   (input valid, op, item_value, position, output ready);
endinterface

// ----- design/olpe_rsp_if.sv -----
// Response channel of the ordered list engine: one result per beat.
// Depends on olpe_pkg for field widths.
interface olpe_rsp_if
    import olpe_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    logic [FIDX_W-1:0]       found_index;
    logic [CNT_W-1:0]        entry_count;
    logic [ST_W-1:0]         status;

    modport source (output valid, result_value, found_index, entry_count, status, input ready);
    modport sink   (input valid, result_value, found_index, entry_count, status, output ready);
endinterface

// ----- design/olpe_cell.sv -----
// One list cell: holds one entry, loads, shifts from a neighbor, compares to a key.
// Depends on olpe_pkg for widths and the cell control struct.
module olpe_cell
    import olpe_pkg::*;
(
    input  logic                    clk,
    input  cell_ctl_t               ctl,
    input  logic signed [VAL_W-1:0] new_value,
    input  logic signed [VAL_W-1:0] left_value,
    input  logic signed [VAL_W-1:0] right_value,
    input  logic signed [VAL_W-1:0] key,
    output logic signed [VAL_W-1:0] value,
    output logic                    match
);

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;

    always_comb
    begin
        priority if (ctl.load)
        begin
            entry_next = new_value;
        end
        else if (ctl.take_left)
        begin
            entry_next = left_value;
        end
        else if (ctl.take_right)
        begin
            entry_next = right_value;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign value = entry_reg;
    assign match = (entry_reg == key);

endmodule

// ----- design/ordered_list_positional_engine_top.sv -----
// Top level of the ordered list engine: a row of list cells plus result register.
// Depends on olpe_pkg, olpe_req_if, olpe_rsp_if, olpe_cell and the assert header.
//
//   channel | role  | beat carries
//   --------+-------+-----------------------------------------------
//   req     | sink  | op, item_value, position
//   rsp     | source| result_value, found_index, entry_count, status
//
// All cells shift, load and compare in parallel for each operation.
// A result sits in the output register; a new request is taken in the same
// cycle the waiting result is taken, so one beat per cycle under no stall.
// Reset empties the list at once; cell contents are undefined until written.
// A stalled rsp holds the result and holds off req.
`include "ordered_list_positional_engine_top_assert.svh"

module ordered_list_positional_engine_top
    import olpe_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    olpe_req_if.sink   req,
    olpe_rsp_if.source rsp
);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] result_value_reg;
    logic signed [VAL_W-1:0] result_value_next;
    logic [FIDX_W-1:0]       found_index_reg;
    logic [FIDX_W-1:0]       found_index_next;
    logic [ST_W-1:0]         status_reg;
    status_t                 status_next;

    logic                    accept;
    logic [CMP_W-1:0]        pos_c;
    logic [CMP_W-1:0]        cnt_c;
    logic [CMP_W-1:0]        ins_pos;
    logic [CMP_W-1:0]        ext_pos;
    logic                    is_full;
    logic                    is_empty;
    logic                    do_insert;
    logic                    do_extract;
    logic [IDX_W-1:0]        rd_idx;
    logic signed [VAL_W-1:0] rd_data;
    logic [IDX_W-1:0]        hit_idx;
    logic                    hit;

    cell_ctl_t               cell_ctl   [DEPTH];
    logic signed [VAL_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]        cell_match;
    logic [DEPTH-1:0]        live_match;

    assign accept   = req.valid && req.ready;
    assign req.ready = !out_valid_reg || rsp.ready;

    assign pos_c    = CMP_W'(req.position);
    assign cnt_c    = CMP_W'(count_reg);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign ins_pos  = (pos_c > cnt_c) ? cnt_c : pos_c;
    assign ext_pos  = (pos_c >= cnt_c) ? (cnt_c - CMP_W'(1)) : pos_c;

    assign do_insert  = accept && (req.op == OP_INSERT) && !is_full;
    assign do_extract = accept && (req.op == OP_EXTRACT) && !is_empty;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            localparam logic [CMP_W-1:0] IDX = CMP_W'(i);

            always_comb
            begin
                cell_ctl[i].load       = do_insert && (IDX == ins_pos);
                cell_ctl[i].take_left  = do_insert && (IDX > ins_pos) && (IDX <= cnt_c);
                cell_ctl[i].take_right = do_extract && (IDX >= ext_pos)
                                         && ((IDX + CMP_W'(1)) < cnt_c);
            end

            olpe_cell u_cell (
                .clk         (clk),
                .ctl         (cell_ctl[i]),
                .new_value   (req.item_value),
                .left_value  (cell_value[(i > 0) ? i - 1 : i]),
                .right_value (cell_value[(i < DEPTH - 1) ? i + 1 : i]),
                .key         (req.item_value),
                .value       (cell_value[i]),
                .match       (cell_match[i])
            );

            assign live_match[i] = cell_match[i] && (IDX < cnt_c);
        end
    endgenerate

    assign rd_idx  = (req.op == OP_EXTRACT) ? ext_pos[IDX_W-1:0] : pos_c[IDX_W-1:0];
    assign rd_data = cell_value[rd_idx];

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            if (live_match[k])
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        result_value_next = '0;
        found_index_next  = '0;
        status_next       = ST_OK;
        count_next        = count_reg;
        unique case (req.op)
            OP_INSERT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_EXTRACT:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    result_value_next = rd_data;
                    count_next        = count_reg - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (is_empty)
                begin
                    result_value_next = MISS_VALUE;
                    status_next       = ST_EMPTY;
                end
                else if (pos_c >= cnt_c)
                begin
                    result_value_next = MISS_VALUE;
                    status_next       = ST_MISS;
                end
                else
                begin
                    result_value_next = rd_data;
                end
            end
            OP_FIND:
            begin
                if (hit)
                begin
                    found_index_next = FIDX_W'(hit_idx);
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            count_reg     <= count_next;
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_value_reg <= result_value_next;
            found_index_reg  <= found_index_next;
            status_reg       <= status_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = result_value_reg;
    assign rsp.found_index  = found_index_reg;
    assign rsp.entry_count  = count_reg;
    assign rsp.status       = status_reg;

    `OLPE_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "count above depth")
    `OLPE_ASSERT_NEXT(a_insert_grow, clk, rst_n, do_insert,
        count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow count")
    `OLPE_ASSERT_NEXT(a_clear_empty, clk, rst_n, accept && (req.op == OP_CLEAR),
        count_reg == '0, "clear left entries")
    `OLPE_ASSERT(a_full_status, clk, rst_n,
        !(rsp.valid && (rsp.status == ST_FULL)) || (rsp.entry_count == CNT_W'(DEPTH)),
        "full status with room left")

endmodule
